[rtl/core/pqdw_pkg.sv]
// pqdw_pkg: shared types, constants and the entry compare function
// for the drop-worst priority queue; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package pqdw_pkg;

   localparam int QUEUE_DEPTH = 64;
   // one extra slot holds the arriving packet while the worst is chosen
   localparam int SLOTS  = QUEUE_DEPTH + 1;
   localparam int ADDR_W = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);

   localparam logic [31:0] BYTE_LIMIT_RESET = 32'd65536;

   localparam logic [1:0] MODE_FIFO = 2'd0;
   localparam logic [1:0] MODE_FAIR = 2'd1;
   localparam logic [1:0] MODE_SRPT = 2'd2;

   localparam logic CSR_ORDER_MODE = 1'b0;
   localparam logic CSR_BYTE_LIMIT = 1'b1;

   localparam logic REQ_ENQ = 1'b0;
   localparam logic REQ_DEQ = 1'b1;

   typedef enum logic [1:0] {
      ST_ACCEPT = 2'd0,
      ST_DROP   = 2'd1,
      ST_DEPART = 2'd2,
      ST_EMPTY  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CMP_LT = 2'd0,
      CMP_EQ = 2'd1,
      CMP_GT = 2'd2
   } cmp_type;

   typedef enum logic [1:0] {
      S_IDLE  = 2'd0,
      S_SCAN  = 2'd1,
      S_SHIFT = 2'd2
   } state_type;

   typedef struct packed {
      logic [31:0] tag;
      logic [15:0] size;
      logic        ack;
      logic [31:0] seq;
      logic [31:0] rank;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   function automatic cmp_type cmp_u32(logic [31:0] x, logic [31:0] y);
      cmp_type r;
      if (x == y) r = CMP_EQ;
      else if (x < y) r = CMP_LT;
      else r = CMP_GT;
      return r;
   endfunction

   // less-than means a is the better entry
   function automatic cmp_type entry_cmp(entry_type a, entry_type b, logic [1:0] mode);
      cmp_type r;
      if (!a.ack && b.ack) r = CMP_GT;
      else if (a.ack) r = b.ack ? CMP_EQ : CMP_LT;
      else if (mode == MODE_FAIR) r = cmp_u32(a.seq, b.seq);
      else if (mode == MODE_SRPT) r = cmp_u32(a.rank, b.rank);
      else r = CMP_EQ;
      return r;
   endfunction

endpackage
`default_nettype wire

[rtl/core/pqdw_ram.sv]
// pqdw_ram: generic single write, single registered read memory
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module pqdw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

[rtl/core/priority_queue_drop_worst.sv]
// priority_queue_drop_worst: byte-limited priority queue, push-out of worst entry
// depends on pqdw_pkg and pqdw_ram
// enqueue with no drop: result registered on the next edge
// drop or dequeue over n entries (the new packet included on a drop): a scan of all n
// entries through the single ram read port and one comparator, then a shift of the later
// entries down one slot to close the gap at w; not ready while scanning or shifting
// reset (synchronous, active high) clears count and bytes, mode to fifo, limit to 65536
`timescale 1ns / 1ps
`default_nettype none
module priority_queue_drop_worst (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_type,
   input  wire logic [31:0] req_pkt_tag,
   input  wire logic [15:0] req_pkt_size,
   input  wire logic        req_pkt_is_ack,
   input  wire logic [31:0] req_pkt_seq,
   input  wire logic [31:0] req_pkt_rank,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_out_tag,
   output logic [15:0]      rsp_out_size,
   output logic             rsp_out_is_ack,
   output logic [31:0]      rsp_out_seq,
   output logic [31:0]      rsp_out_rank,
   output logic [31:0]      rsp_bytes_held,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata
);
   localparam int CNT_W  = pqdw_pkg::CNT_W;
   localparam int ADDR_W = pqdw_pkg::ADDR_W;

   // control state
   pqdw_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [31:0]         total_ff, total_in;
   logic [1:0]          mode_ff;
   logic [31:0]         limit_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                pend_ff, pend_in;

   // datapath
   logic [CNT_W-1:0]    scan_n_ff, scan_n_in;
   logic [CNT_W-1:0]    issue_ff, issue_in;
   logic [CNT_W-1:0]    pend_idx_ff, pend_idx_in;
   logic [CNT_W-1:0]    best_idx_ff, best_idx_in;
   pqdw_pkg::entry_type best_ff, best_in;
   logic                worst_ff, worst_in;
   logic [32:0]         acc_ff, acc_in;
   pqdw_pkg::status_type rsp_status_ff, rsp_status_in;
   pqdw_pkg::entry_type  rsp_pkt_ff, rsp_pkt_in;
   logic [31:0]          rsp_bytes_ff, rsp_bytes_in;

   // ram port
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
   pqdw_pkg::entry_type mem_wdata, mem_rdata;

   pqdw_ram #(
      .WIDTH(pqdw_pkg::ENTRY_W),
      .DEPTH(pqdw_pkg::SLOTS)
   ) u_ram (
      .clock(clock),
      .we(mem_we),
      .waddr(mem_waddr),
      .wdata(mem_wdata),
      .raddr(mem_raddr),
      .rdata(mem_rdata)
   );

   // one beat in only when idle and the result slot frees up
   assign req_ready = (state_ff == pqdw_pkg::S_IDLE) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pqdw_pkg::S_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         mode_ff      <= pqdw_pkg::MODE_FIFO;
         limit_ff     <= pqdw_pkg::BYTE_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         if (csr_we) begin
            unique case (csr_index)
               pqdw_pkg::CSR_ORDER_MODE: mode_ff  <= csr_wdata[1:0];
               pqdw_pkg::CSR_BYTE_LIMIT: limit_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      scan_n_ff     <= scan_n_in;
      issue_ff      <= issue_in;
      pend_idx_ff   <= pend_idx_in;
      best_idx_ff   <= best_idx_in;
      best_ff       <= best_in;
      worst_ff      <= worst_in;
      acc_ff        <= acc_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pkt_ff    <= rsp_pkt_in;
      rsp_bytes_ff  <= rsp_bytes_in;
   end

   always_comb begin
      logic [32:0]       sum;
      logic [32:0]       diff;
      logic              take;
      logic              last;
      logic [CNT_W-1:0]  wdx;
      pqdw_pkg::cmp_type c;

      state_in      = state_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      rsp_valid_in  = rsp_valid_ff;
      pend_in       = pend_ff;
      scan_n_in     = scan_n_ff;
      issue_in      = issue_ff;
      pend_idx_in   = pend_idx_ff;
      best_idx_in   = best_idx_ff;
      best_in       = best_ff;
      worst_in      = worst_ff;
      acc_in        = acc_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pkt_in    = rsp_pkt_ff;
      rsp_bytes_in  = rsp_bytes_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_raddr     = '0;
      mem_wdata     = '{tag: req_pkt_tag, size: req_pkt_size, ack: req_pkt_is_ack,
                        seq: req_pkt_seq, rank: req_pkt_rank};
      sum           = {1'b0, total_ff} + {17'b0, req_pkt_size};
      diff          = acc_ff - {17'b0, best_ff.size};
      c             = pqdw_pkg::entry_cmp(mem_rdata, best_ff, mode_ff);
      take          = 1'b0;
      last          = 1'b0;
      wdx           = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         pqdw_pkg::S_IDLE: begin
            if (req_valid && req_ready) begin
               issue_in = '0;
               pend_in  = 1'b0;
               if (req_type == pqdw_pkg::REQ_ENQ) begin
                  // new packet lands in the slot after the last entry
                  mem_we    = 1'b1;
                  mem_waddr = count_ff[ADDR_W-1:0];
                  if ((sum > {1'b0, limit_ff}) ||
                      (count_ff == CNT_W'(pqdw_pkg::QUEUE_DEPTH))) begin
                     scan_n_in = count_ff + CNT_W'(1);
                     worst_in  = 1'b1;
                     acc_in    = sum;
                     state_in  = pqdw_pkg::S_SCAN;
                  end else begin
                     count_in      = count_ff + CNT_W'(1);
                     total_in      = sum[31:0];
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = pqdw_pkg::ST_ACCEPT;
                     rsp_pkt_in    = '0;
                     rsp_bytes_in  = sum[31:0];
                  end
               end else begin
                  if (count_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = pqdw_pkg::ST_EMPTY;
                     rsp_pkt_in    = '0;
                     rsp_bytes_in  = total_ff;
                  end else begin
                     scan_n_in = count_ff;
                     worst_in  = 1'b0;
                     acc_in    = {1'b0, total_ff};
                     state_in  = pqdw_pkg::S_SCAN;
                  end
               end
            end
         end

         pqdw_pkg::S_SCAN: begin
            // read one entry a cycle, compare against the running pick
            if (pend_ff) begin
               if (worst_ff) take = (c != pqdw_pkg::CMP_LT);
               else take = (c == pqdw_pkg::CMP_LT);
               if (pend_idx_ff == '0) take = 1'b1;
               wdx = best_idx_ff;
               if (take) begin
                  best_in     = mem_rdata;
                  best_idx_in = pend_idx_ff;
                  wdx         = pend_idx_ff;
               end
               last = (pend_idx_ff == scan_n_ff - CNT_W'(1));
            end
            if (last) begin
               pend_in  = 1'b0;
               issue_in = wdx + CNT_W'(1);
               state_in = pqdw_pkg::S_SHIFT;
            end else if (issue_ff < scan_n_ff) begin
               mem_raddr   = issue_ff[ADDR_W-1:0];
               pend_in     = 1'b1;
               pend_idx_in = issue_ff;
               issue_in    = issue_ff + CNT_W'(1);
            end else begin
               pend_in = 1'b0;
            end
         end

         pqdw_pkg::S_SHIFT: begin
            // move each later entry down one slot over the removed one
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = ADDR_W'(pend_idx_ff - CNT_W'(1));
               mem_wdata = mem_rdata;
            end
            if (issue_ff < scan_n_ff) begin
               mem_raddr   = issue_ff[ADDR_W-1:0];
               pend_in     = 1'b1;
               pend_idx_in = issue_ff;
               issue_in    = issue_ff + CNT_W'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  count_in      = scan_n_ff - CNT_W'(1);
                  total_in      = diff[31:0];
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = worst_ff ? pqdw_pkg::ST_DROP : pqdw_pkg::ST_DEPART;
                  rsp_pkt_in    = best_ff;
                  rsp_bytes_in  = diff[31:0];
                  state_in      = pqdw_pkg::S_IDLE;
               end
            end
         end

         default: state_in = pqdw_pkg::S_IDLE;
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_tag    = rsp_pkt_ff.tag;
   assign rsp_out_size   = rsp_pkt_ff.size;
   assign rsp_out_is_ack = rsp_pkt_ff.ack;
   assign rsp_out_seq    = rsp_pkt_ff.seq;
   assign rsp_out_rank   = rsp_pkt_ff.rank;
   assign rsp_bytes_held = rsp_bytes_ff;

   // store never holds more than its depth between beats
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(pqdw_pkg::QUEUE_DEPTH))
      else $error("entry count above depth");

   // result slot is empty while a scan or shift runs
   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff != pqdw_pkg::S_IDLE) |-> !rsp_valid_ff)
      else $error("result pending during scan");

   // accept and empty carry no packet
   a_zero_pkt: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == pqdw_pkg::ST_ACCEPT ||
                        rsp_status_ff == pqdw_pkg::ST_EMPTY)) |-> (rsp_pkt_ff == '0))
      else $error("packet fields on accept or empty");

   // a finished scan always leads into the shift phase
   a_scan_to_shift: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pqdw_pkg::S_SCAN && pend_ff && pend_idx_ff == scan_n_ff - CNT_W'(1))
      |=> (state_ff == pqdw_pkg::S_SHIFT))
      else $error("scan did not end in shift");

endmodule
`default_nettype wire
